[rtl/pcpd_pkg.sv]
// ----------------------------------------------------------------------------
// pcpd_pkg: shared tables and helpers for the CRY pixel decoder
// Chroma lookup tables and the divide-by-255 helper for intensity scaling.
// ----------------------------------------------------------------------------
package pcpd_pkg;

   typedef logic [7:0] chroma_type;

   localparam int PALETTE_ENTRIES = 256;

   // red chroma, indexed {red nibble, cyan nibble}; blue uses the inverted red nibble
   localparam chroma_type RED_CHROMA [256] = '{
        8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
        8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
        8'd34,  8'd34,  8'd34,  8'd34,  8'd34,  8'd34,  8'd34,  8'd34,
        8'd34,  8'd34,  8'd34,  8'd34,  8'd34,  8'd34,  8'd19,  8'd0,
        8'd68,  8'd68,  8'd68,  8'd68,  8'd68,  8'd68,  8'd68,  8'd68,
        8'd68,  8'd68,  8'd68,  8'd68,  8'd64,  8'd43,  8'd21,  8'd0,
        8'd102, 8'd102, 8'd102, 8'd102, 8'd102, 8'd102, 8'd102, 8'd102,
        8'd102, 8'd102, 8'd102, 8'd95,  8'd71,  8'd47,  8'd23,  8'd0,
        8'd135, 8'd135, 8'd135, 8'd135, 8'd135, 8'd135, 8'd135, 8'd135,
        8'd135, 8'd135, 8'd130, 8'd104, 8'd78,  8'd52,  8'd26,  8'd0,
        8'd169, 8'd169, 8'd169, 8'd169, 8'd169, 8'd169, 8'd169, 8'd169,
        8'd169, 8'd170, 8'd141, 8'd113, 8'd85,  8'd56,  8'd28,  8'd0,
        8'd203, 8'd203, 8'd203, 8'd203, 8'd203, 8'd203, 8'd203, 8'd203,
        8'd203, 8'd183, 8'd153, 8'd122, 8'd91,  8'd61,  8'd30,  8'd0,
        8'd237, 8'd237, 8'd237, 8'd237, 8'd237, 8'd237, 8'd237, 8'd237,
        8'd230, 8'd197, 8'd164, 8'd131, 8'd98,  8'd65,  8'd32,  8'd0,
        8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
        8'd247, 8'd214, 8'd181, 8'd148, 8'd115, 8'd82,  8'd49,  8'd17,
        8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
        8'd255, 8'd235, 8'd204, 8'd173, 8'd143, 8'd112, 8'd81,  8'd51,
        8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
        8'd255, 8'd255, 8'd227, 8'd198, 8'd170, 8'd141, 8'd113, 8'd85,
        8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
        8'd255, 8'd255, 8'd249, 8'd223, 8'd197, 8'd171, 8'd145, 8'd119,
        8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
        8'd255, 8'd255, 8'd255, 8'd248, 8'd224, 8'd200, 8'd177, 8'd153,
        8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
        8'd255, 8'd255, 8'd255, 8'd255, 8'd252, 8'd230, 8'd208, 8'd187,
        8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
        8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd240, 8'd221,
        8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
        8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255
   };

   // green chroma, upper half of the red range folds onto these eight rows
   localparam chroma_type GREEN_CHROMA [128] = '{
        8'd0, 8'd17, 8'd34, 8'd51, 8'd68,  8'd85,  8'd102, 8'd119,
        8'd136, 8'd153, 8'd170, 8'd187, 8'd204, 8'd221, 8'd238, 8'd255,
        8'd0, 8'd19, 8'd38, 8'd57, 8'd77,  8'd96,  8'd115, 8'd134,
        8'd154, 8'd173, 8'd192, 8'd211, 8'd231, 8'd250, 8'd255, 8'd255,
        8'd0, 8'd21, 8'd43, 8'd64, 8'd86,  8'd107, 8'd129, 8'd150,
        8'd172, 8'd193, 8'd215, 8'd236, 8'd255, 8'd255, 8'd255, 8'd255,
        8'd0, 8'd23, 8'd47, 8'd71, 8'd95,  8'd119, 8'd142, 8'd166,
        8'd190, 8'd214, 8'd238, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
        8'd0, 8'd26, 8'd52, 8'd78, 8'd104, 8'd130, 8'd156, 8'd182,
        8'd208, 8'd234, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
        8'd0, 8'd28, 8'd56, 8'd85, 8'd113, 8'd141, 8'd170, 8'd198,
        8'd226, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
        8'd0, 8'd30, 8'd61, 8'd91, 8'd122, 8'd153, 8'd183, 8'd214,
        8'd244, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
        8'd0, 8'd32, 8'd65, 8'd98, 8'd131, 8'd164, 8'd197, 8'd230,
        8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255
   };

   localparam logic [2:0] DEPTH_1BPP  = 3'd0;
   localparam logic [2:0] DEPTH_2BPP  = 3'd1;
   localparam logic [2:0] DEPTH_4BPP  = 3'd2;
   localparam logic [2:0] DEPTH_16BPP = 3'd4;

   // floor(x / 255), exact for products of two bytes
   function automatic logic [7:0] div255(input logic [15:0] x);
      logic [16:0] sum;
      sum = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
      return sum[15:8];
   endfunction

endpackage

[rtl/palette_cry_pixel_decoder.sv]
// ----------------------------------------------------------------------------
// palette_cry_pixel_decoder: per-pixel palette lookup and CRY to RGB565
// Stages from req accept to rsp_valid: palette read, chroma multiply,
// scale and pack. Throughput: one word per cycle, write or pixel, unless stalled.
// Each stage moves when the next one is empty or moving, so bubbles absorb
// output stalls. Reset clears the stage valid bits; the palette is not cleared.
// ----------------------------------------------------------------------------
module palette_cry_pixel_decoder
   import pcpd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_mode,
   input  logic [23:0] req_pixel_value,
   input  logic [2:0]  req_depth_code,
   input  logic [6:0]  req_palette_base,
   input  logic        req_transparent_enable,
   input  logic        req_cry_mode,
   input  logic [7:0]  req_palette_write_addr,
   input  logic [15:0] req_palette_write_word,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_color,
   output logic        rsp_transparent
);

   localparam int AW = $clog2(PALETTE_ENTRIES);

   logic [15:0] palette_mem [PALETTE_ENTRIES];

   // stage 1: palette read
   logic        s1_valid_ff, s1_valid_in;
   logic        s1_pal_ff, s1_cry_ff, s1_tr_ff, s1_is24_ff;
   logic [15:0] s1_direct_ff;
   logic [15:0] rdata_ff;
   // stage 2: chroma products
   logic        s2_valid_ff, s2_valid_in;
   logic        s2_cry_ff, s2_tr_ff;
   logic [15:0] s2_pass_ff;
   logic [15:0] prod_r_ff, prod_g_ff, prod_b_ff;
   // stage 3: output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_color_ff;
   logic        rsp_tr_ff;

   logic s1_ready, s2_ready, s3_ready;
   logic acc, acc_pix;
   logic s1_ld, s2_ld;

   assign s3_ready  = !rsp_valid_ff || rsp_ready;
   assign s2_ready  = !s2_valid_ff || s3_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign req_ready = s1_ready;
   assign acc       = req_valid && req_ready;
   assign acc_pix   = acc && !req_mode;
   assign s1_ld     = s1_valid_ff && s2_ready;
   assign s2_ld     = s2_valid_ff && s3_ready;

   // ---------------- stage 0: address and classification ----------------
   logic [7:0]  idx_pix;
   logic [7:0]  rd_addr;
   logic        pix_zero;
   logic        is_pal, is24;
   logic [15:0] direct_word;

   always_comb begin
      is_pal = (req_depth_code < DEPTH_16BPP);
      is24   = (req_depth_code > DEPTH_16BPP);
      idx_pix  = req_pixel_value[7:0];
      rd_addr  = req_pixel_value[7:0];
      unique case (req_depth_code)
         DEPTH_1BPP: begin
            idx_pix = {7'd0, req_pixel_value[0]};
            rd_addr = {req_palette_base, req_pixel_value[0]};
         end
         DEPTH_2BPP: begin
            idx_pix = {6'd0, req_pixel_value[1:0]};
            rd_addr = {req_palette_base[6:1], req_pixel_value[1:0]};
         end
         DEPTH_4BPP: begin
            idx_pix = {4'd0, req_pixel_value[3:0]};
            rd_addr = {req_palette_base[6:3], req_pixel_value[3:0]};
         end
         default: begin
            idx_pix = req_pixel_value[7:0];
            rd_addr = req_pixel_value[7:0];
         end
      endcase
      if (is_pal) begin
         pix_zero = (idx_pix == 8'd0);
      end else begin
         pix_zero = (req_pixel_value[15:0] == 16'd0);
      end
      if (is24) begin
         direct_word = {req_pixel_value[23:19], req_pixel_value[15:10],
                        req_pixel_value[7:3]};
      end else begin
         direct_word = req_pixel_value[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (acc && req_mode) begin
         palette_mem[req_palette_write_addr[AW-1:0]] <= req_palette_write_word;
      end
      if (acc_pix) begin
         rdata_ff <= palette_mem[rd_addr[AW-1:0]];
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (s1_ready) begin
         s1_valid_in = acc_pix;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (acc_pix) begin
         s1_pal_ff    <= is_pal;
         s1_is24_ff   <= is24;
         s1_cry_ff    <= req_cry_mode;
         s1_tr_ff     <= req_transparent_enable && pix_zero && !is24;
         s1_direct_ff <= direct_word;
      end
   end

   // ---------------- stage 1 -> 2: chroma lookup and multiply ----------------
   logic [15:0] word;
   logic [2:0]  g_row;
   chroma_type  r_c, g_c, b_c;
   logic        use_cry;

   always_comb begin
      word    = s1_pal_ff ? rdata_ff : s1_direct_ff;
      use_cry = s1_cry_ff && !s1_tr_ff && !s1_is24_ff;
      g_row   = word[15] ? ~word[14:12] : word[14:12];
      r_c     = RED_CHROMA[word[15:8]];
      b_c     = RED_CHROMA[{~word[15:12], word[11:8]}];
      g_c     = GREEN_CHROMA[{g_row, word[11:8]}];
   end

   always_comb begin
      s2_valid_in = s2_valid_ff;
      if (s2_ready) begin
         s2_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
      end
      if (s1_ld) begin
         s2_cry_ff  <= use_cry;
         s2_tr_ff   <= s1_tr_ff;
         s2_pass_ff <= s1_tr_ff ? 16'd0 : word;
         prod_r_ff  <= r_c * word[7:0];
         prod_g_ff  <= g_c * word[7:0];
         prod_b_ff  <= b_c * word[7:0];
      end
   end

   // ---------------- stage 2 -> 3: scale by Y/255 and pack ----------------
   logic [7:0]  sr, sg, sb;
   logic [15:0] cry_color;

   always_comb begin
      sr        = div255(prod_r_ff);
      sg        = div255(prod_g_ff);
      sb        = div255(prod_b_ff);
      cry_color = {sr[7:3], sg[7:2], sb[7:3]};
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s3_ready) begin
         rsp_valid_in = s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (s2_ld) begin
         rsp_color_ff <= s2_cry_ff ? cry_color : s2_pass_ff;
         rsp_tr_ff    <= s2_tr_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_color       = rsp_color_ff;
   assign rsp_transparent = rsp_tr_ff;

endmodule

[rtl/pcpd_checker.sv]
// ----------------------------------------------------------------------------
// pcpd_checker: port-level checks for the CRY pixel decoder
// Watches the top-level ports and flags handshake and pipeline slips.
// ----------------------------------------------------------------------------
module pcpd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_color,
   input logic        rsp_transparent
);

   // stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_color)
         && $stable(rsp_transparent))
      else $error("rsp word changed while stalled");

   // transparent mark carries a zero color
   a_tr_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_transparent |-> rsp_color == 16'd0)
      else $error("transparent word with nonzero color");

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid after reset");

   // with the output register empty every stage can move
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("req_ready low with empty output");

endmodule

bind palette_cry_pixel_decoder pcpd_checker u_pcpd_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_color       (rsp_color),
   .rsp_transparent (rsp_transparent)
);
